// File: hw/rtl/set_assoc_cache_tag_controller_unit_defines.svh
// Assertion macros used by the cache tag controller unit.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_UNIT_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define SACT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define SACT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg
// Types and constants shared by the set-associative cache tag controller.
// ----------------------------------------------------------------------------
package sact_pkg;

   localparam int unsigned CfgIdxW = 3;

   typedef enum logic [CfgIdxW-1:0] {
      REG_INDEX_BITS     = 3'd0,
      REG_WAYS_LOG2      = 3'd1,
      REG_OFFSET_BITS    = 3'd2,
      REG_REPLACE_FIFO   = 3'd3,
      REG_WRITE_BACK     = 3'd4,
      REG_WRITE_ALLOCATE = 3'd5
   } cfg_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOOKUP,
      ST_CLEAR
   } state_type;

   localparam int unsigned CostW      = 18;
   localparam int unsigned TotalW     = 48;
   localparam int unsigned CntW       = 32;
   localparam int unsigned StampW     = 32;
   localparam int unsigned AddrW      = 32;
   localparam int unsigned MinOffset  = 2;
   localparam int unsigned MaxOffset  = 12;
   localparam logic [CostW-1:0] CostHit       = 18'd1;
   localparam logic [CostW-1:0] CostStoreThru = 18'd102;
   localparam logic [CostW-1:0] CostBypass    = 18'd101;
   localparam int unsigned BeatCost   = 25;

endpackage

// File: hw/rtl/sact_ram.sv
// ----------------------------------------------------------------------------
// sact_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sact_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// File: hw/rtl/set_assoc_cache_tag_controller_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_unit
// Cache tag lookup, replacement and cycle accounting for loads and stores.
// ----------------------------------------------------------------------------
// Channel  Dir  Content
// req_     in   tuser = kind, tdata = address
// rsp_     out  tdata = hit, access_cycles, total_cycles, four counters
// csr_     in   register write: index, data
//
// An accepted beat first reads its whole set from the set RAM in ST_READ,
// then in ST_LOOKUP compares the ways, chooses a victim and writes the set
// back (unless the access bypasses); the result register is loaded as
// ST_LOOKUP ends. After reset a clearing pass over all MAX_SETS sets zeroes
// the valid and dirty marks in the set RAM; no request beat is taken during it.
// The result waits in an output register; a new request is taken only once
// the register is free, so a stalled rsp_ side holds req_.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_controller_unit_defines.svh"

module set_assoc_cache_tag_controller_unit #(
   parameter int unsigned MAX_SETS = 256,
   parameter int unsigned MAX_WAYS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tuser,   // [0] kind
   input  logic [31:0]   req_tdata,   // [31:0] address
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [0] hit, [18:1] access_cycles, [66:19] total_cycles, [98:67] load_hits,
   // [130:99] load_misses, [162:131] store_hits, [194:163] store_misses
   output logic [199:0]  rsp_tdata,
   input  logic          csr_wr_en,
   input  logic [sact_pkg::CfgIdxW-1:0] csr_index,
   input  logic [3:0]    csr_data
);
   import sact_pkg::*;

   localparam int unsigned SetW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int unsigned IbMax = $clog2(MAX_SETS);
   localparam int unsigned WayW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int unsigned WlMax = $clog2(MAX_WAYS);
   localparam int unsigned TagW  = AddrW - MinOffset;
   // per way: valid, dirty, tag, last-use stamp, fill stamp
   localparam int unsigned EntW  = 2 + TagW + 2 * StampW;
   localparam int unsigned RowW  = EntW * MAX_WAYS;

   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [TagW-1:0]  tag;
      logic [StampW-1:0] used;
      logic [StampW-1:0] filled;
   } entry_type;

   // configuration
   logic [3:0] index_bits_ff;
   logic [1:0] ways_log2_ff;
   logic [3:0] offset_bits_ff;
   logic       replace_fifo_ff, write_back_ff, write_allocate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff     <= '0;
         ways_log2_ff      <= '0;
         offset_bits_ff    <= 4'(MinOffset);
         replace_fifo_ff   <= 1'b0;
         write_back_ff     <= 1'b0;
         write_allocate_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (cfg_reg_type'(csr_index))
            REG_INDEX_BITS:     index_bits_ff     <= csr_data;
            REG_WAYS_LOG2:      ways_log2_ff      <= csr_data[1:0];
            REG_OFFSET_BITS:    offset_bits_ff    <= csr_data;
            REG_REPLACE_FIFO:   replace_fifo_ff   <= csr_data[0];
            REG_WRITE_BACK:     write_back_ff     <= csr_data[0];
            REG_WRITE_ALLOCATE: write_allocate_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // state
   state_type state_ff, state_in;
   logic [SetW-1:0]   clr_ff, clr_in;
   logic              kind_ff;
   logic [AddrW-1:0]  addr_ff;
   logic [StampW-1:0] count_ff;
   logic [CntW-1:0]   lh_ff, lm_ff, sh_ff, sm_ff;
   logic [TotalW-1:0] total_ff;
   logic              out_valid_ff;
   logic              out_hit_ff;
   logic [CostW-1:0]  out_cost_ff;

   // effective split, from the registered address
   logic [3:0] ob;
   logic [3:0] ib;
   logic [5:0] ob_ib;
   logic [SetW-1:0] set_sel;
   logic [AddrW-1:0] set_mask;
   logic [TagW-1:0] tag_cur;
   logic [AddrW-1:0] shifted;

   always_comb begin
      ob = (offset_bits_ff < 4'(MinOffset)) ? 4'(MinOffset)
         : ((offset_bits_ff > 4'(MaxOffset)) ? 4'(MaxOffset) : offset_bits_ff);
      ib = (int'(index_bits_ff) > IbMax) ? 4'(IbMax) : index_bits_ff;
      ob_ib = 6'(ob) + 6'(ib);
      shifted  = addr_ff >> ob;
      set_mask = (AddrW'(1) << ib) - AddrW'(1);
      set_sel  = SetW'(shifted & set_mask);
      tag_cur  = (ob_ib >= 6'd32) ? '0 : TagW'(addr_ff >> ob_ib);
   end

   // set RAM
   logic            ram_we;
   logic [SetW-1:0] ram_addr;
   logic [RowW-1:0] ram_wdata, ram_rdata;

   sact_ram #(.WIDTH(RowW), .DEPTH(1 << SetW)) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // way compare and victim choice
   entry_type       ent [MAX_WAYS];
   logic [WayW:0]   ways_n;
   logic            hit;
   logic [WayW-1:0] hit_way, inv_way, old_way, victim;
   logic            inv_found;
   logic [StampW-1:0] best, s;
   logic            fill, victim_dirty;
   logic [CostW-1:0] fill_cost, cost;
   logic [1:0]      wl;

   always_comb begin
      wl = (int'(ways_log2_ff) > WlMax) ? 2'(WlMax) : ways_log2_ff;
      ways_n = (WayW+1)'(1) << wl;
      hit = 1'b0; hit_way = '0; inv_found = 1'b0; inv_way = '0;
      old_way = '0; best = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         ent[w] = entry_type'(ram_rdata[w*EntW +: EntW]);
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (w < int'(ways_n)) begin
            if (ent[w].valid && ent[w].tag == tag_cur) begin
               hit = 1'b1; hit_way = WayW'(w);
            end
            if (!ent[w].valid) begin
               inv_found = 1'b1; inv_way = WayW'(w);
            end
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         s = replace_fifo_ff ? ent[w].filled : ent[w].used;
         if (w == 0) begin
            best = s; old_way = '0;
         end else if (w < int'(ways_n) && s < best) begin
            best = s; old_way = WayW'(w);
         end
      end
      fill_cost = CostW'(BeatCost) * (CostW'(1) << ob) + CostW'(1);
      fill = !hit && !(kind_ff && !write_allocate_ff);
      victim = hit ? hit_way : (inv_found ? inv_way : old_way);
      victim_dirty = !inv_found && ent[old_way].dirty;
      if (hit) begin
         cost = (kind_ff && !write_back_ff) ? CostStoreThru : CostHit;
      end else if (!fill) begin
         cost = CostBypass;
      end else begin
         cost = victim_dirty ? (fill_cost << 1) : fill_cost;
      end
   end

   // write-back row
   always_comb begin
      ram_wdata = ram_rdata;
      ram_we = 1'b0;
      ram_addr = set_sel;
      if (state_ff == ST_CLEAR) begin
         ram_wdata = '0;
         ram_we = 1'b1;
         ram_addr = clr_ff;
      end else if (state_ff == ST_LOOKUP) begin
         ram_we = hit || fill;
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (WayW'(w) == victim) begin
               if (hit) begin
                  ram_wdata[w*EntW +: EntW] = {1'b1,
                     ent[w].dirty || (kind_ff && write_back_ff),
                     ent[w].tag, count_ff, ent[w].filled};
               end else begin
                  ram_wdata[w*EntW +: EntW] = {1'b1, kind_ff && write_back_ff,
                     tag_cur, count_ff, count_ff};
               end
            end
         end
      end
   end

   // sequencer
   logic req_acc, rsp_acc, done;
   assign req_tready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign done = state_ff == ST_LOOKUP;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SetW'(1);
            if (clr_ff == SetW'(MAX_SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE:   if (req_acc) state_in = ST_READ;
         ST_READ:   state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff <= req_tuser;
         addr_ff <= req_tdata;
      end
   end

   // The set is addressed from addr_ff, so its read is issued in ST_READ and
   // the registered row is compared and written back in ST_LOOKUP. The next
   // read of any set comes after that write, so no forwarding is needed.
   logic [TotalW:0] tsum;
   assign tsum = {1'b0, total_ff} + (TotalW+1)'(cost);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; lh_ff <= '0; lm_ff <= '0; sh_ff <= '0; sm_ff <= '0;
         total_ff <= '0; out_valid_ff <= 1'b0;
      end else begin
         if (rsp_acc) out_valid_ff <= 1'b0;
         if (done) begin
            count_ff <= count_ff + StampW'(1);
            total_ff <= tsum[TotalW] ? '1 : tsum[TotalW-1:0];
            if (hit && !kind_ff && lh_ff != '1) lh_ff <= lh_ff + CntW'(1);
            if (!hit && !kind_ff && lm_ff != '1) lm_ff <= lm_ff + CntW'(1);
            if (hit && kind_ff && sh_ff != '1) sh_ff <= sh_ff + CntW'(1);
            if (!hit && kind_ff && sm_ff != '1) sm_ff <= sm_ff + CntW'(1);
            out_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         out_hit_ff  <= hit;
         out_cost_ff <= cost;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'd0, sm_ff, sh_ff, lm_ff, lh_ff, total_ff, out_cost_ff,
                       out_hit_ff};

   `SACT_ASSERT_IMP(a_no_req_in_clear, clock, reset,
      state_ff == ST_CLEAR, !req_tready, "request taken during clear")
   `SACT_ASSERT_NXT(a_accept_to_read, clock, reset,
      req_acc, state_ff == ST_READ, "accepted beat did not start the set read")
   `SACT_ASSERT_IMP(a_no_overwrite, clock, reset,
      out_valid_ff && !rsp_acc, !done, "result overwritten")
endmodule
